>>> hw/rtl/clc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_pkg - chat line classifier shared definitions
// line limits, character codes, command keyword tables and result type
// ----------------------------------------------------------------------------
package clc_pkg;

	// longest accepted line in bytes, trailing carriage return excluded
	localparam int MAX_LINE = 1024;
	localparam int POS_W    = $clog2(MAX_LINE + 1);

	localparam int CHAR_W   = 8;
	localparam int ARGS_W   = 3;
	localparam int TLEN_W   = 10;
	localparam int CSTART_W = 10;
	localparam int LLEN_W   = 11;
	localparam int OUT_BITS = 4 + ARGS_W + TLEN_W + CSTART_W + LLEN_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'd35;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
	localparam logic [CHAR_W-1:0] CH_AT    = 8'd64;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'd126;

	typedef enum logic [3:0] {
		KIND_REJECT      = 4'd0,
		KIND_SUBSCRIBE   = 4'd1,
		KIND_UNSUBSCRIBE = 4'd2,
		KIND_DELETE      = 4'd3,
		KIND_USER_LIST   = 4'd4,
		KIND_LOGOUT      = 4'd5,
		KIND_DIRECT      = 4'd6,
		KIND_GROUP       = 4'd7,
		KIND_GLOBAL      = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		MODE_UNKNOWN = 2'd0,
		MODE_CMD     = 2'd1,
		MODE_TARGET  = 2'd2,
		MODE_GLOBAL  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [LLEN_W-1:0]   line_length;
		logic [CSTART_W-1:0] content_start;
		logic [TLEN_W-1:0]   target_length;
		logic [ARGS_W-1:0]   arg_count;
		kind_t               kind;
	} result_t;

	// command keywords, text right-aligned so the last character is the low byte
	localparam int KW_COUNT  = 6;
	localparam int KW_MAXLEN = 11;
	localparam int KW_IDX_W  = $clog2(KW_MAXLEN);

	localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"subscribe", "unsubscribe", "delete", "listusers", "list_users", "logout"
	};
	localparam int KW_LEN [KW_COUNT] = '{9, 11, 6, 9, 10, 6};
	localparam kind_t KW_KIND [KW_COUNT] = '{
		KIND_SUBSCRIBE, KIND_UNSUBSCRIBE, KIND_DELETE,
		KIND_USER_LIST, KIND_USER_LIST, KIND_LOGOUT
	};
	localparam logic [ARGS_W-1:0] KW_ARGS [KW_COUNT] = '{
		3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0
	};

	// keyword k has character c at offset idx
	function automatic logic kw_char_match(input int k, input logic [POS_W-1:0] idx,
			input logic [CHAR_W-1:0] c);
		logic [KW_IDX_W-1:0] i;
		logic                hit;
		i   = idx[KW_IDX_W-1:0];
		hit = 1'b0;
		if (idx < POS_W'(KW_LEN[k])) begin
			hit = (KW_TEXT[k][(KW_LEN[k] - 1 - int'(i)) * 8 +: 8] == c);
		end
		return hit;
	endfunction

	// keywords whose length equals len
	function automatic logic [KW_COUNT-1:0] kw_len_mask(input logic [POS_W-1:0] len);
		logic [KW_COUNT-1:0] m;
		for (int k = 0; k < KW_COUNT; k++) begin
			m[k] = (len == POS_W'(KW_LEN[k]));
		end
		return m;
	endfunction

endpackage

>>> hw/rtl/chat_line_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chat_line_classifier_top - chat line classifier
// streams line bytes in and returns one classification per line
// ----------------------------------------------------------------------------
// usage
//   slave stream: one byte of a chat line per transaction in s_tdata, with
//   s_tlast high on the final byte of the line
//   master stream: one result transaction per line, issued for the byte that
//   carried s_tlast; no transaction for any other byte
//   throughput: one byte per cycle, sustained, including back-to-back lines,
//   while no final byte waits in the input register on m_tready; set by the
//   update of the per-line state from the input register as each byte advances
//   result path: a final byte is held in the input register; when it
//   advances, its result is loaded into the output register and is offered on
//   m_tvalid from then on
//   stall: while a result waits on m_tready, bytes that do not close a line
//   keep flowing through; only a further final byte waits in the input
//   register, and s_tready drops once that register is blocked
//   reset: arst_n clears both registers' valid flags and returns the line
//   state to the start of a line
// ----------------------------------------------------------------------------
module chat_line_classifier_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [clc_pkg::CHAR_W-1:0]  s_tdata,  // char_in
	input  logic                        s_tlast,  // last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [clc_pkg::OUT_W-1:0]   m_tdata   // kind, arg_count, target_length,
	                                              // content_start, line_length, zero pad
);

	// input register
	logic                        valid_s1;
	logic [clc_pkg::CHAR_W-1:0]  char_s1;
	logic                        last_s1;

	// output register
	logic                        out_valid_q;
	clc_pkg::result_t            out_q;

	clc_pkg::result_t            result;
	logic                        out_free;
	logic                        advance;

	// a byte that closes no line never needs the output register
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// running line state and end of line decision
	clc_line_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.char_in (char_s1),
		.last    (last_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = clc_pkg::OUT_W'(out_q);

endmodule

>>> hw/rtl/clc_line_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_line_tracker - per-line running state and classification
// folds one byte into the line state and forms the result on the last byte
// ----------------------------------------------------------------------------
module clc_line_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [clc_pkg::CHAR_W-1:0]  char_in,
	input  logic                        last,
	output clc_pkg::result_t            result
);

	localparam int POS_W = clc_pkg::POS_W;
	localparam int KW_N  = clc_pkg::KW_COUNT;
	localparam int EXT_W = POS_W + clc_pkg::LLEN_W + 1;

	logic [POS_W-1:0]            pos_q, nx_pos;
	clc_pkg::mode_t              mode_q, nx_mode;
	logic [KW_N-1:0]             hits_q, nx_hits, fin_hits;
	logic                        tok_q, nx_tok;
	logic [clc_pkg::ARGS_W-1:0]  args_q, nx_args;
	logic                        bad_q, nx_bad, fin_bad;
	logic                        space_q, nx_space;
	logic [POS_W-1:0]            tlen_q, nx_tlen;
	logic                        group_q, nx_group;
	logic                        kwfin_q, nx_kwfin;

	logic                        printable;
	logic                        cr_end;
	logic [POS_W-1:0]            pos_m1;
	logic [POS_W-1:0]            end_m1;
	logic                        found;
	logic [EXT_W-1:0]            pos_ext, tlen_ext, cstart_ext;

	always_comb begin
		printable = (char_in >= clc_pkg::CH_SPACE) && (char_in <= clc_pkg::CH_TILDE);
		cr_end    = last && (char_in == clc_pkg::CH_CR);
		pos_m1    = pos_q - POS_W'(1);

		nx_pos   = pos_q;
		nx_mode  = mode_q;
		nx_hits  = hits_q;
		nx_tok   = tok_q;
		nx_args  = args_q;
		nx_bad   = bad_q;
		nx_space = space_q;
		nx_tlen  = tlen_q;
		nx_group = group_q;
		nx_kwfin = kwfin_q;

		if (!cr_end) begin
			if (!printable || (pos_q >= POS_W'(clc_pkg::MAX_LINE))) begin
				nx_bad = 1'b1;
			end
			if (!nx_bad) begin
				nx_pos = pos_q + POS_W'(1);
				if (pos_q == '0) begin
					// first byte picks the line form
					priority if (char_in == clc_pkg::CH_SLASH) begin
						nx_mode = clc_pkg::MODE_CMD;
					end else if (char_in == clc_pkg::CH_AT) begin
						nx_mode  = clc_pkg::MODE_TARGET;
						nx_group = 1'b0;
					end else if (char_in == clc_pkg::CH_HASH) begin
						nx_mode  = clc_pkg::MODE_TARGET;
						nx_group = 1'b1;
					end else begin
						nx_mode = clc_pkg::MODE_GLOBAL;
					end
				end else if (mode_q == clc_pkg::MODE_CMD) begin
					if (!kwfin_q) begin
						if (char_in == clc_pkg::CH_SPACE) begin
							nx_hits  = hits_q & clc_pkg::kw_len_mask(pos_m1);
							nx_kwfin = 1'b1;
							if (nx_hits == '0) begin
								nx_bad = 1'b1;
							end
						end else begin
							for (int k = 0; k < KW_N; k++) begin
								if (!clc_pkg::kw_char_match(k, pos_m1, char_in)) begin
									nx_hits[k] = 1'b0;
								end
							end
						end
					end else if (char_in == clc_pkg::CH_SPACE) begin
						nx_tok = 1'b0;
					end else if (!tok_q) begin
						nx_tok = 1'b1;
						if (args_q != '1) begin
							nx_args = args_q + clc_pkg::ARGS_W'(1);
						end
					end
				end else if (mode_q == clc_pkg::MODE_TARGET) begin
					if ((char_in == clc_pkg::CH_SPACE) && !space_q) begin
						nx_space = 1'b1;
						nx_tlen  = pos_m1;
						if (pos_q == POS_W'(1)) begin
							nx_bad = 1'b1;
						end
					end
				end
			end
		end

		// end of line classification
		end_m1     = nx_pos - POS_W'(1);
		fin_bad    = nx_bad;
		fin_hits   = nx_hits;
		found      = 1'b0;
		pos_ext    = EXT_W'(nx_pos);
		tlen_ext   = EXT_W'(nx_tlen);
		cstart_ext = tlen_ext + EXT_W'(2);
		result     = '0;
		result.kind = clc_pkg::KIND_REJECT;
		if (!nx_bad && (nx_pos != '0)) begin
			unique case (nx_mode)
				clc_pkg::MODE_CMD: begin
					if (!nx_kwfin) begin
						fin_hits = nx_hits & clc_pkg::kw_len_mask(end_m1);
						if (fin_hits == '0) begin
							fin_bad = 1'b1;
						end
					end
					if (!fin_bad) begin
						for (int k = 0; k < KW_N; k++) begin
							if (!found && fin_hits[k]) begin
								found = 1'b1;
								if (nx_args == clc_pkg::KW_ARGS[k]) begin
									result.kind        = clc_pkg::KW_KIND[k];
									result.arg_count   = nx_args;
									result.line_length = pos_ext[clc_pkg::LLEN_W-1:0];
								end
							end
						end
					end
				end
				clc_pkg::MODE_TARGET: begin
					if (nx_space && (nx_tlen != '0) && (pos_ext >= tlen_ext + EXT_W'(3))) begin
						result.kind          = nx_group ? clc_pkg::KIND_GROUP
						                                : clc_pkg::KIND_DIRECT;
						result.target_length = tlen_ext[clc_pkg::TLEN_W-1:0];
						result.content_start = cstart_ext[clc_pkg::CSTART_W-1:0];
						result.line_length   = pos_ext[clc_pkg::LLEN_W-1:0];
					end
				end
				clc_pkg::MODE_GLOBAL: begin
					result.kind        = clc_pkg::KIND_GLOBAL;
					result.line_length = pos_ext[clc_pkg::LLEN_W-1:0];
				end
				default: begin
					result.kind = clc_pkg::KIND_REJECT;
				end
			endcase
		end
	end

	// state returns to its cleared value once a line closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mode_q  <= clc_pkg::MODE_UNKNOWN;
			hits_q  <= '1;
			tok_q   <= 1'b0;
			args_q  <= '0;
			bad_q   <= 1'b0;
			space_q <= 1'b0;
			tlen_q  <= '0;
			group_q <= 1'b0;
			kwfin_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				pos_q   <= '0;
				mode_q  <= clc_pkg::MODE_UNKNOWN;
				hits_q  <= '1;
				tok_q   <= 1'b0;
				args_q  <= '0;
				bad_q   <= 1'b0;
				space_q <= 1'b0;
				tlen_q  <= '0;
				group_q <= 1'b0;
				kwfin_q <= 1'b0;
			end else begin
				pos_q   <= nx_pos;
				mode_q  <= nx_mode;
				hits_q  <= nx_hits;
				tok_q   <= nx_tok;
				args_q  <= nx_args;
				bad_q   <= nx_bad;
				space_q <= nx_space;
				tlen_q  <= nx_tlen;
				group_q <= nx_group;
				kwfin_q <= nx_kwfin;
			end
		end
	end

endmodule
